// ===== design/dd_odo_pkg.sv =====
`default_nettype none
package dd_odo_pkg;

  localparam int unsigned CORDIC_STEPS_DEF = 24;
  localparam int unsigned CNT_W            = 5;

  localparam logic [31:0] MPT_RESET  = 32'd4294967;
  localparam logic [31:0] HHPT_RESET = 32'd1499029;

  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [33:0] ONE_Q30     = 34'sd1073741824;
  localparam logic signed [33:0] M_ONE_Q30   = -34'sd1073741824;

  localparam logic [23:0] US_PER_S   = 24'd1000000;
  localparam logic [23:0] FOUR_PI_E6 = 24'd12566371;

  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

  // register indexes on the config port
  localparam logic REG_MPT  = 1'b0;
  localparam logic REG_HHPT = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE,
    S_MWL,
    S_MWR,
    S_DS,
    S_HS,
    S_COR,
    S_CFIN,
    S_MXH,
    S_MXL,
    S_MYH,
    S_MYL,
    S_YA,
    S_H2,
    S_V0,
    S_V1,
    S_V2,
    S_DCHK,
    S_DIV,
    S_DFIN,
    S_A0,
    S_A1,
    S_OUT
  } state_e;

  // arctangent of 2^-i in binary angle units
  function automatic logic [31:0] atan_bam(input logic [CNT_W-1:0] i);
    logic [31:0] r;
    case (i)
      5'd0:    r = 32'd536870912;
      5'd1:    r = 32'd316933406;
      5'd2:    r = 32'd167458907;
      5'd3:    r = 32'd85004756;
      5'd4:    r = 32'd42667331;
      5'd5:    r = 32'd21354465;
      5'd6:    r = 32'd10679838;
      5'd7:    r = 32'd5340245;
      5'd8:    r = 32'd2670163;
      5'd9:    r = 32'd1335087;
      5'd10:   r = 32'd667544;
      5'd11:   r = 32'd333772;
      5'd12:   r = 32'd166886;
      5'd13:   r = 32'd83443;
      5'd14:   r = 32'd41722;
      5'd15:   r = 32'd20861;
      5'd16:   r = 32'd10430;
      5'd17:   r = 32'd5215;
      5'd18:   r = 32'd2608;
      5'd19:   r = 32'd1304;
      5'd20:   r = 32'd652;
      5'd21:   r = 32'd326;
      5'd22:   r = 32'd163;
      5'd23:   r = 32'd81;
      5'd24:   r = 32'd41;
      5'd25:   r = 32'd20;
      5'd26:   r = 32'd10;
      5'd27:   r = 32'd5;
      5'd28:   r = 32'd3;
      5'd29:   r = 32'd1;
      5'd30:   r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/dd_odo_in_if.sv =====
`default_nettype none
interface dd_odo_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] left_count;
  logic signed [31:0] right_count;
  logic        [31:0] elapsed_us;

  modport source (output valid, left_count, right_count, elapsed_us, input ready);
  modport sink   (input valid, left_count, right_count, elapsed_us, output ready);
endinterface
`default_nettype wire

// ===== design/dd_odo_out_if.sv =====
`default_nettype none
interface dd_odo_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] x_pos;
  logic signed [63:0] y_pos;
  logic signed [31:0] orient_z;
  logic signed [31:0] orient_w;
  logic signed [31:0] linear_vel;
  logic signed [31:0] angular_vel;

  modport source (output valid, x_pos, y_pos, orient_z, orient_w, linear_vel,
                  angular_vel, input ready);
  modport sink   (input valid, x_pos, y_pos, orient_z, orient_w, linear_vel,
                  angular_vel, output ready);
endinterface
`default_nettype wire

// ===== design/diff_drive_odometry_top.sv =====
`default_nettype none
// channel   dir  handshake      payload
// in_i      in   valid/ready    left_count, right_count, elapsed_us
// out_o     out  valid/ready    x_pos, y_pos, orient_z, orient_w, linear_vel, angular_vel
// apb       in   psel/penable   meters_per_tick (0x0), half_heading_per_tick (0x4)
//
// one request at a time: a report that gives a result keeps the block busy through the two
// cordic passes and the two 32-step restoring divisions before the result is offered; a
// division that saturates is skipped, and all of it shares one 34x34 multiplier
// a priming report or a zero-time report is taken with no result
// the result waits in the output registers until out_o.ready; no new request meanwhile
// reset clears pose, heading, stored counts and the primed flag; config goes to defaults
module diff_drive_odometry_top #(
  parameter int unsigned CORDIC_STEPS = dd_odo_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  dd_odo_in_if.sink        in_i,
  dd_odo_out_if.source     out_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int unsigned CW = dd_odo_pkg::CNT_W;

  dd_odo_pkg::state_e state_q, state_d;

  // config
  logic [31:0] mpt_q, hhpt_q;

  // architectural state
  logic               primed_q;
  logic [31:0]        prevl_q, prevr_q;
  logic [63:0]        xacc_q, yacc_q;
  logic [31:0]        hh_q;

  // working registers
  logic signed [31:0] dl_q, dr_q;
  logic [31:0]        el_q;
  logic signed [32:0] k_q;
  logic [31:0]        kmag_q;
  logic [63:0]        wl_q, prod_q, ds_q, amag_q;
  logic [31:0]        hstep_q;
  logic signed [33:0] cx_q, cy_q, cz_q;
  logic [1:0]         qd_q;
  logic               pass_q, vsel_q, big_q;
  logic [CW-1:0]      cnt_q;
  logic signed [31:0] sin_q, cos_q, lin_q, angv_q;
  logic [87:0]        n_q;
  logic [47:0]        rem_q;

  logic in_acc, out_acc, cfg_wr;
  assign in_acc  = in_i.valid && in_i.ready;
  assign out_acc = out_o.valid && out_o.ready;
  assign cfg_wr  = psel && penable && pwrite && pready;

  // apb
  assign pready = 1'b1;
  always_comb begin
    case (paddr[2])
      dd_odo_pkg::REG_MPT:  prdata = mpt_q;
      dd_odo_pkg::REG_HHPT: prdata = hhpt_q;
      default:              prdata = mpt_q;
    endcase
  end

  // shared multiplier, operands picked by the sequencer
  logic signed [33:0] ma, mb;
  logic signed [67:0] mp;
  logic [23:0]        bconst;
  assign bconst = vsel_q ? dd_odo_pkg::FOUR_PI_E6 : dd_odo_pkg::US_PER_S;
  assign mp     = ma * mb;

  always_comb begin
    ma = '0;
    mb = '0;
    case (state_q)
      dd_odo_pkg::S_MWL: begin
        ma = {{2{dl_q[31]}}, dl_q};
        mb = {2'b00, mpt_q};
      end
      dd_odo_pkg::S_MWR: begin
        ma = {{2{dr_q[31]}}, dr_q};
        mb = {2'b00, mpt_q};
      end
      dd_odo_pkg::S_DS: begin
        ma = {k_q[32], k_q};
        mb = {2'b00, hhpt_q};
      end
      dd_odo_pkg::S_MXH: begin
        ma = {{2{ds_q[63]}}, ds_q[63:32]};
        mb = {{2{cos_q[31]}}, cos_q};
      end
      dd_odo_pkg::S_MXL: begin
        ma = {2'b00, ds_q[31:0]};
        mb = {{2{cos_q[31]}}, cos_q};
      end
      dd_odo_pkg::S_MYH: begin
        ma = {{2{ds_q[63]}}, ds_q[63:32]};
        mb = {{2{sin_q[31]}}, sin_q};
      end
      dd_odo_pkg::S_MYL: begin
        ma = {2'b00, ds_q[31:0]};
        mb = {{2{sin_q[31]}}, sin_q};
      end
      dd_odo_pkg::S_A0: begin
        ma = {2'b00, kmag_q};
        mb = {2'b00, hhpt_q};
      end
      dd_odo_pkg::S_V0: begin
        ma = {2'b00, amag_q[31:0]};
        mb = {10'b0, bconst};
      end
      dd_odo_pkg::S_V1: begin
        ma = {2'b00, amag_q[63:32]};
        mb = {10'b0, bconst};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  // cordic start: quadrant fold of the angle
  logic [31:0] ang, ang_t, ang_r;
  assign ang   = (state_q == dd_odo_pkg::S_HS) ? ({hh_q[30:0], 1'b0} + prod_q[31:0]) : hh_q;
  assign ang_t = ang + dd_odo_pkg::QUARTER_TURN;
  assign ang_r = ang - {ang_t[31:30], 30'b0};

  // cordic micro-rotation
  logic signed [33:0] xs, ys;
  logic [31:0]        atn;
  assign xs  = cx_q >>> cnt_q;
  assign ys  = cy_q >>> cnt_q;
  assign atn = dd_odo_pkg::atan_bam(cnt_q);

  // quadrant unfold and clamp
  logic signed [33:0] cs_u, sn_u;
  always_comb begin
    case (qd_q)
      2'd0: begin
        cs_u = cx_q;
        sn_u = cy_q;
      end
      2'd1: begin
        cs_u = -cy_q;
        sn_u = cx_q;
      end
      2'd2: begin
        cs_u = -cx_q;
        sn_u = -cy_q;
      end
      default: begin
        cs_u = cy_q;
        sn_u = -cx_q;
      end
    endcase
  end

  function automatic logic signed [31:0] clamp_q30(input logic signed [33:0] v);
    logic signed [33:0] r;
    if (v > dd_odo_pkg::ONE_Q30) begin
      r = dd_odo_pkg::ONE_Q30;
    end else if (v < dd_odo_pkg::M_ONE_Q30) begin
      r = dd_odo_pkg::M_ONE_Q30;
    end else begin
      r = v;
    end
    return r[31:0];
  endfunction

  // divider step
  logic [48:0] r2, d49;
  logic        ge;
  assign d49 = {1'b0, el_q, 16'b0};
  assign r2  = {rem_q, n_q[31]};
  assign ge  = (r2 >= d49);

  logic [64:0] ds_sum;
  assign ds_sum = {wl_q[63], wl_q} + {prod_q[63], prod_q};

  logic        vneg;
  logic [31:0] qv, vsat;
  assign vneg = vsel_q ? k_q[32] : ds_q[63];
  assign qv   = n_q[31:0];
  always_comb begin
    if (vneg) begin
      vsat = (big_q || qv[31]) ? 32'h8000_0000 : (32'd0 - qv);
    end else begin
      vsat = (big_q || qv[31]) ? 32'h7FFF_FFFF : qv;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      dd_odo_pkg::S_IDLE: begin
        if (in_acc && primed_q && (in_i.elapsed_us != '0)) state_d = dd_odo_pkg::S_MWL;
      end
      dd_odo_pkg::S_MWL: state_d = dd_odo_pkg::S_MWR;
      dd_odo_pkg::S_MWR: state_d = dd_odo_pkg::S_DS;
      dd_odo_pkg::S_DS:  state_d = dd_odo_pkg::S_HS;
      dd_odo_pkg::S_HS:  state_d = dd_odo_pkg::S_COR;
      dd_odo_pkg::S_COR: begin
        if (cnt_q == CW'(CORDIC_STEPS - 1)) state_d = dd_odo_pkg::S_CFIN;
      end
      dd_odo_pkg::S_CFIN: state_d = pass_q ? dd_odo_pkg::S_V0 : dd_odo_pkg::S_MXH;
      dd_odo_pkg::S_MXH:  state_d = dd_odo_pkg::S_MXL;
      dd_odo_pkg::S_MXL:  state_d = dd_odo_pkg::S_MYH;
      dd_odo_pkg::S_MYH:  state_d = dd_odo_pkg::S_MYL;
      dd_odo_pkg::S_MYL:  state_d = dd_odo_pkg::S_YA;
      dd_odo_pkg::S_YA:   state_d = dd_odo_pkg::S_H2;
      dd_odo_pkg::S_H2:   state_d = dd_odo_pkg::S_COR;
      dd_odo_pkg::S_V0:   state_d = dd_odo_pkg::S_V1;
      dd_odo_pkg::S_V1:   state_d = dd_odo_pkg::S_V2;
      dd_odo_pkg::S_V2:   state_d = dd_odo_pkg::S_DCHK;
      dd_odo_pkg::S_DCHK: begin
        state_d = (n_q[87:32] >= {8'b0, el_q, 16'b0}) ? dd_odo_pkg::S_DFIN
                                                       : dd_odo_pkg::S_DIV;
      end
      dd_odo_pkg::S_DIV: begin
        if (cnt_q == {CW{1'b1}}) state_d = dd_odo_pkg::S_DFIN;
      end
      dd_odo_pkg::S_DFIN: state_d = vsel_q ? dd_odo_pkg::S_OUT : dd_odo_pkg::S_A0;
      dd_odo_pkg::S_A0:   state_d = dd_odo_pkg::S_A1;
      dd_odo_pkg::S_A1:   state_d = dd_odo_pkg::S_V0;
      dd_odo_pkg::S_OUT: begin
        if (out_acc) state_d = dd_odo_pkg::S_IDLE;
      end
      default: state_d = dd_odo_pkg::S_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_i.ready  = (state_q == dd_odo_pkg::S_IDLE);
    out_o.valid = (state_q == dd_odo_pkg::S_OUT);
  end

  assign out_o.x_pos       = xacc_q;
  assign out_o.y_pos       = yacc_q;
  assign out_o.orient_z    = sin_q;
  assign out_o.orient_w    = cos_q;
  assign out_o.linear_vel  = lin_q;
  assign out_o.angular_vel = angv_q;

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= dd_odo_pkg::S_IDLE;
      mpt_q    <= dd_odo_pkg::MPT_RESET;
      hhpt_q   <= dd_odo_pkg::HHPT_RESET;
      primed_q <= 1'b0;
      prevl_q  <= '0;
      prevr_q  <= '0;
      xacc_q   <= '0;
      yacc_q   <= '0;
      hh_q     <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_wr) begin
        case (paddr[2])
          dd_odo_pkg::REG_MPT:  mpt_q  <= pwdata;
          dd_odo_pkg::REG_HHPT: hhpt_q <= pwdata;
          default:              mpt_q  <= pwdata;
        endcase
      end
      if (state_q == dd_odo_pkg::S_IDLE && in_acc) begin
        if (!primed_q) begin
          primed_q <= 1'b1;
          prevl_q  <= in_i.left_count;
          prevr_q  <= in_i.right_count;
        end else if (in_i.elapsed_us != '0) begin
          prevl_q  <= in_i.left_count;
          prevr_q  <= in_i.right_count;
        end
      end
      case (state_q)
        dd_odo_pkg::S_MXL: xacc_q <= xacc_q + {prod_q[61:0], 2'b00};
        dd_odo_pkg::S_MYH: xacc_q <= xacc_q + 64'($signed(prod_q) >>> 30);
        dd_odo_pkg::S_MYL: yacc_q <= yacc_q + {prod_q[61:0], 2'b00};
        dd_odo_pkg::S_YA: begin
          yacc_q <= yacc_q + 64'($signed(prod_q) >>> 30);
          hh_q   <= hh_q + hstep_q;
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      dd_odo_pkg::S_IDLE: begin
        dl_q <= in_i.left_count - prevl_q;
        dr_q <= in_i.right_count - prevr_q;
        el_q <= in_i.elapsed_us;
      end
      dd_odo_pkg::S_MWL: begin
        wl_q <= mp[63:0];
        k_q  <= {dr_q[31], dr_q} - {dl_q[31], dl_q};
      end
      dd_odo_pkg::S_MWR: prod_q <= mp[63:0];
      dd_odo_pkg::S_DS: begin
        ds_q   <= ds_sum[64:1];
        prod_q <= mp[63:0];
        kmag_q <= k_q[32] ? 32'(-k_q) : k_q[31:0];
      end
      dd_odo_pkg::S_HS, dd_odo_pkg::S_H2: begin
        if (state_q == dd_odo_pkg::S_HS) hstep_q <= prod_q[31:0];
        pass_q <= (state_q == dd_odo_pkg::S_H2);
        qd_q   <= ang_t[31:30];
        cx_q   <= dd_odo_pkg::CORDIC_GAIN;
        cy_q   <= '0;
        cz_q   <= {{2{ang_r[31]}}, ang_r};
        cnt_q  <= '0;
      end
      dd_odo_pkg::S_COR: begin
        if (!cz_q[33]) begin
          cx_q <= cx_q - ys;
          cy_q <= cy_q + xs;
          cz_q <= cz_q - $signed({2'b00, atn});
        end else begin
          cx_q <= cx_q + ys;
          cy_q <= cy_q - xs;
          cz_q <= cz_q + $signed({2'b00, atn});
        end
        cnt_q <= cnt_q + 1'b1;
      end
      dd_odo_pkg::S_CFIN: begin
        cos_q  <= clamp_q30(cs_u);
        sin_q  <= clamp_q30(sn_u);
        vsel_q <= 1'b0;
      end
      dd_odo_pkg::S_MXH, dd_odo_pkg::S_MXL, dd_odo_pkg::S_MYH, dd_odo_pkg::S_MYL:
        prod_q <= mp[63:0];
      dd_odo_pkg::S_YA: amag_q <= ds_q[63] ? (64'd0 - ds_q) : ds_q;
      dd_odo_pkg::S_V0: prod_q <= mp[63:0];
      dd_odo_pkg::S_V1: begin
        n_q    <= {24'b0, prod_q};
        prod_q <= mp[63:0];
      end
      dd_odo_pkg::S_V2: n_q <= n_q + {prod_q[55:0], 32'b0};
      dd_odo_pkg::S_DCHK: begin
        big_q <= (n_q[87:32] >= {8'b0, el_q, 16'b0});
        rem_q <= n_q[79:32];
        cnt_q <= '0;
      end
      dd_odo_pkg::S_DIV: begin
        rem_q      <= ge ? 48'(r2 - d49) : r2[47:0];
        n_q[31:0]  <= {n_q[30:0], ge};
        cnt_q      <= cnt_q + 1'b1;
      end
      dd_odo_pkg::S_DFIN: begin
        if (vsel_q) angv_q <= vsat;
        else        lin_q  <= vsat;
        vsel_q <= 1'b1;
      end
      dd_odo_pkg::S_A0: prod_q <= mp[63:0];
      dd_odo_pkg::S_A1: amag_q <= prod_q;
      default: ;
    endcase
  end

  // checks
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !out_o.valid)
    else $error("request taken while a result is pending");

  a_back_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |=> in_i.ready)
    else $error("not ready after the result was taken");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && primed_q && (in_i.elapsed_us != '0)) |=> !in_i.ready)
    else $error("working request did not leave idle");

  a_orient_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> ((out_o.orient_z <= 32'sd1073741824) &&
                     (out_o.orient_z >= -32'sd1073741824) &&
                     (out_o.orient_w <= 32'sd1073741824) &&
                     (out_o.orient_w >= -32'sd1073741824)))
    else $error("quaternion out of range");

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // arctangent of 2^-i, binary angle, for the default cordic depth
  localparam int unsigned N_STEPS = 24;
  localparam logic [31:0] ATAN_TAB [N_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef struct {
    logic [63:0] x;
    logic [63:0] y;
    logic [31:0] z;
    logic [31:0] w;
    logic [31:0] lv;
    logic [31:0] av;
  } pose_t;

  // tracks pose state and holds the poses still owed by the block
  class odo_scoreboard;
    logic [31:0] mpt, hhpt, prev_l, prev_r, half_hd;
    logic [63:0] x_acc, y_acc;
    bit primed;
    pose_t pose_q[$];
    int errors;
    int checked;

    function new();
      mpt = dd_odo_pkg::MPT_RESET;
      hhpt = dd_odo_pkg::HHPT_RESET;
      prev_l = '0;
      prev_r = '0;
      half_hd = '0;
      x_acc = '0;
      y_acc = '0;
      primed = 0;
      errors = 0;
      checked = 0;
    endfunction

    function void set_reg(logic idx, logic [31:0] v);
      if (idx == dd_odo_pkg::REG_MPT) mpt = v;
      else hhpt = v;
    endfunction

    function int pending();
      return pose_q.size();
    endfunction

    // rotation-mode cordic with quadrant fold, clamped to +-1.0 in q1.30
    function automatic void sin_cos(input logic [31:0] a, output longint sn,
                                    output longint cs);
      logic [1:0] qd;
      logic [31:0] r;
      longint z, x, y, xs, ys;
      qd = 2'((a + dd_odo_pkg::QUARTER_TURN) >> 30);
      r = a - {qd, 30'b0};
      z = longint'(signed'(r));
      x = 652032874;
      y = 0;
      for (int i = 0; i < N_STEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x -= ys; y += xs; z -= longint'({32'b0, ATAN_TAB[i]});
        end else begin
          x += ys; y -= xs; z += longint'({32'b0, ATAN_TAB[i]});
        end
      end
      case (qd)
        2'd0: begin cs = x;  sn = y;  end
        2'd1: begin cs = -y; sn = x;  end
        2'd2: begin cs = -x; sn = -y; end
        default: begin cs = y; sn = -x; end
      endcase
      if (cs > 1073741824) cs = 1073741824;
      if (cs < -1073741824) cs = -1073741824;
      if (sn > 1073741824) sn = 1073741824;
      if (sn < -1073741824) sn = -1073741824;
    endfunction

    // floor(d*k/2^30) split into halves, wrapping
    function automatic logic [63:0] scale_q30(longint d, longint k);
      longint hi, lo;
      hi = d >>> 32;
      lo = d & 64'hFFFF_FFFF;
      return ((hi * k) << 2) + ((lo * k) >>> 30);
    endfunction

    // trunc(a*b/d), capped at 2^32
    function automatic logic [32:0] rate_mag(logic [63:0] a, logic [31:0] b,
                                             logic [63:0] d);
      logic [127:0] n, q;
      n = {64'b0, a} * {96'b0, b};
      q = n / {64'b0, d};
      return (q > 128'hFFFF_FFFF) ? 33'h1_0000_0000 : q[32:0];
    endfunction

    function automatic logic [31:0] clip_rate(logic [32:0] mag, bit neg);
      if (neg) return (mag >= 33'h8000_0000) ? 32'h8000_0000 : -mag[31:0];
      return (mag > 33'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    endfunction

    function void note_request(logic [31:0] lc, logic [31:0] rc, logic [31:0] el);
      logic [31:0] tl, tr, hstep, mid;
      logic [63:0] dsm, km, kh, d;
      longint dl, dr, wl, wr, ds, k, sn, cs;
      pose_t p;
      if (!primed) begin
        prev_l = lc;
        prev_r = rc;
        primed = 1;
        return;
      end
      if (el == 0) return;
      tl = lc - prev_l;
      tr = rc - prev_r;
      dl = longint'(signed'(tl));
      dr = longint'(signed'(tr));
      prev_l = lc;
      prev_r = rc;
      wl = dl * longint'({32'b0, mpt});
      wr = dr * longint'({32'b0, mpt});
      ds = (wl >>> 1) + (wr >>> 1) + (wl & wr & 64'sd1);
      k = dr - dl;
      hstep = 32'(k * longint'({32'b0, hhpt}));
      // midpoint of the full heading is twice the half heading plus half the step
      mid = {half_hd[30:0], 1'b0} + hstep;
      sin_cos(mid, sn, cs);
      x_acc += scale_q30(ds, cs);
      y_acc += scale_q30(ds, sn);
      half_hd += hstep;
      sin_cos(half_hd, sn, cs);
      d = {16'b0, el, 16'b0};
      dsm = (ds < 0) ? -ds : ds;
      km = (k < 0) ? -k : k;
      kh = km * {32'b0, hhpt};
      p.x = x_acc;
      p.y = y_acc;
      p.z = 32'(sn);
      p.w = 32'(cs);
      p.lv = clip_rate(rate_mag(dsm, 32'd1000000, d), ds < 0);
      p.av = clip_rate(rate_mag(kh, 32'd12566371, d), k < 0);
      pose_q.push_back(p);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("%0t pose mismatch %s: got %h want %h", $realtime, what, got, want);
      errors++;
    endtask

    task check_result(pose_t got);
      pose_t e;
      if (pose_q.size() == 0) begin
        report("unexpected pose", got.x, 64'h0);
        return;
      end
      e = pose_q.pop_front();
      checked++;
      if (got.x !== e.x) report("x_pos", got.x, e.x);
      if (got.y !== e.y) report("y_pos", got.y, e.y);
      if (got.z !== e.z) report("orient_z", got.z, e.z);
      if (got.w !== e.w) report("orient_w", got.w, e.w);
      if (got.lv !== e.lv) report("linear_vel", got.lv, e.lv);
      if (got.av !== e.av) report("angular_vel", got.av, e.av);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  dd_odo_in_if in_if ();
  dd_odo_out_if out_if ();

  diff_drive_odometry_top dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #10 clk = ~clk;

  odo_scoreboard sb = new();
  int send_idle = 0;    // percent of cycles the sender sits idle between requests
  int recv_stall = 0;   // percent of cycles the receiver drops ready
  int hold_left = 0;    // long receiver hold-off, counted down below
  int n_sent = 0;
  logic [31:0] cur_l = '0, cur_r = '0;

  // receiver: check each accepted pose, then pick next ready
  initial begin
    pose_t got;
    out_if.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_if.valid && out_if.ready) begin
        got.x = out_if.x_pos;
        got.y = out_if.y_pos;
        got.z = out_if.orient_z;
        got.w = out_if.orient_w;
        got.lv = out_if.linear_vel;
        got.av = out_if.angular_vel;
        sb.check_result(got);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  // config write: setup then access cycle
  task apb_write(logic idx, logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    sb.set_reg(idx, v);
  endtask

  // offer one request, hold until taken, then maybe idle
  task send_report(logic [31:0] lc, logic [31:0] rc, logic [31:0] el);
    int gap;
    in_if.valid <= 1'b1;
    in_if.left_count <= lc;
    in_if.right_count <= rc;
    in_if.elapsed_us <= el;
    do @(posedge clk); while (!in_if.ready);
    sb.note_request(lc, rc, el);
    n_sent++;
    // the block moves its stored counts on the priming request and on primed nonzero-time requests
    if (el != 0 || n_sent == 1) begin
      cur_l = lc;
      cur_r = rc;
    end
    gap = 0;
    while ($urandom_range(99) < send_idle) gap++;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task step(logic [31:0] dl, logic [31:0] dr, logic [31:0] el);
    send_report(cur_l + dl, cur_r + dr, el);
  endtask

  // wait out every owed pose plus the worst busy stretch before touching config
  task drain();
    in_if.valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task random_reports(int count);
    logic [31:0] el, dl, dr;
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      dl = 32'($signed($urandom_range(4000)) - 2000);
      dr = 32'($signed($urandom_range(4000)) - 2000);
      if (pick < 10) begin
        dl = $urandom;
        dr = $urandom;
      end
      pick = $urandom_range(99);
      if (pick < 5) el = '0;
      else if (pick < 10) el = $urandom;
      else if (pick < 15) el = $urandom_range(10, 1);
      else el = $urandom_range(300000, 1);
      step(dl, dr, el);
    end
  endtask

  initial begin
    in_if.valid <= 1'b0;
    in_if.left_count <= '0;
    in_if.right_count <= '0;
    in_if.elapsed_us <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // phase 0: reset config, no idling, directed corners first
    apb_write(dd_odo_pkg::REG_MPT, dd_odo_pkg::MPT_RESET);
    apb_write(dd_odo_pkg::REG_HHPT, dd_odo_pkg::HHPT_RESET);
    send_report(32'h7FFF_FFF0, 32'h8000_0010, 32'd0);   // priming, zero time
    send_report(32'h1234_5678, 32'h0, 32'd0);           // zero time after priming
    step(32'd21, 32'hFFFF_FFE8, 32'd1000);              // both counters wrap
    step(32'd100, 32'd100, 32'd1);                      // fast forward saturates
    step(-32'd100, -32'd100, 32'd1);                    // fast reverse saturates
    step(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);  // largest step, longest time
    step(32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF);  // most negative step
    step(32'h8000_0000, 32'h7FFF_FFFF, 32'd7);          // widest spin
    step(32'd0, 32'd0, 32'd50);                         // standing still
    step(-32'd500, 32'd500, 32'd1);                     // spin in place
    step(32'd500, -32'd500, 32'd200000);
    send_report(32'hFFFF_FFFF, 32'h0000_0000, 32'd12345);
    send_report(32'h0000_0000, 32'hFFFF_FFFF, 32'd0);
    step(32'd3, 32'd5, 32'd1);
    // long receiver hold-off while requests keep coming
    hold_left = 800;
    for (int i = 0; i < 8; i++) step(32'd40, 32'd60, 32'd200000);
    random_reports(375);
    drain();

    // phase 1: maximum scales, sender idle most of the time
    apb_write(dd_odo_pkg::REG_MPT, 32'hFFFF_FFFF);
    apb_write(dd_odo_pkg::REG_HHPT, 32'hFFFF_FFFF);
    send_idle = 70;
    random_reports(385);
    drain();

    // phase 2: zero scales, receiver stalling
    apb_write(dd_odo_pkg::REG_MPT, 32'h0);
    apb_write(dd_odo_pkg::REG_HHPT, 32'h0);
    send_idle = 0;
    recv_stall = 70;
    random_reports(385);
    drain();

    // phase 3: random scales, both sides idling
    apb_write(dd_odo_pkg::REG_MPT, $urandom);
    apb_write(dd_odo_pkg::REG_HHPT, $urandom);
    send_idle = 30;
    recv_stall = 30;
    random_reports(385);
    drain();

    $display("sent %0d reports over four scale settings and idle mixes, %0d poses checked",
             n_sent, sb.checked);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout with %0d poses owed", sb.pending());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
`default_nettype wire
